// File: design/pclm_pkg.sv
// ----------------------------------------------------------------------------
// pclm_pkg: shared types and codes of the pooled circular list manager
// Field widths, request and status codes, sequencer operations, jump
// conditions and the control word and flag groups passed between modules.
// ----------------------------------------------------------------------------
package pclm_pkg;

   localparam int unsigned NODES_DEF = 16;

   localparam int unsigned TYPE_W     = 2;
   localparam int unsigned KEY_W      = 32;
   localparam int unsigned STATUS_W   = 2;
   localparam int unsigned SLOT_W     = 4;
   localparam int unsigned COUNT_W    = 5;
   localparam int unsigned RSP_DATA_W = 16;
   localparam int unsigned PC_W       = 5;

   // request codes carried on req_tuser
   localparam logic [TYPE_W-1:0] REQ_INSERT = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_DELETE = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_CLEAR  = 2'd2;

   // status codes carried on rsp_tuser
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_SET_DONE,
      OP_SCAN_INIT,
      OP_SCAN_STEP,
      OP_INS_CLAIM,
      OP_INS_LINK,
      OP_SET_FULL,
      OP_WALK_INIT,
      OP_WALK_ADV,
      OP_SET_MISSING,
      OP_UNLINK,
      OP_CLEAR,
      OP_EMIT
   } pclm_op_type;

   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NO_ACCEPT,
      C_IS_INSERT,
      C_IS_DELETE,
      C_IS_CLEAR,
      C_COUNT_FULL,
      C_COUNT_ZERO,
      C_SLOT_USED,
      C_MISS_MORE,
      C_KEY_MATCH,
      C_OUT_FREE
   } pclm_cond_type;

   typedef struct packed {
      pclm_op_type       op;
      pclm_cond_type     cond;
      logic [PC_W-1:0]   target;
   } pclm_ucode_type;

   typedef struct packed {
      logic accept;
      logic is_insert;
      logic is_delete;
      logic is_clear;
      logic count_full;
      logic count_zero;
      logic slot_used;
      logic miss_more;
      logic key_match;
      logic out_free;
   } pclm_flags_type;

endpackage

// File: design/pooled_circular_list_manager.sv
// ----------------------------------------------------------------------------
// pooled_circular_list_manager: circular linked list in a fixed node pool
// Microcoded control over key and link memories, used bits, head, tail
// and node count; one result item per request item.
// ----------------------------------------------------------------------------
// One request is handled at a time, stepped by a microcode sequencer that
// scans the used bits one slot per cycle and walks the list one node per
// cycle through the single read port of the key and link memories. An insert
// scans from slot 0 up to the lowest free slot, or skips the scan when the
// pool is full; a delete walks from the head to the first matching node, or
// over all nodes when the key is absent, and skips the walk on an empty
// list; clear and the unused request code need neither. A new request is
// taken while the previous result still waits in the output register; its
// own result then waits until that register is free. No clearing pass is
// needed after reset.
module pooled_circular_list_manager #(
   parameter int unsigned NODES = pclm_pkg::NODES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pclm_pkg::KEY_W-1:0]        req_tdata,  // [31:0] key
   input  logic [pclm_pkg::TYPE_W-1:0]       req_tuser,  // [1:0] req_type
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [pclm_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // [3:0] slot, [8:4] count
   output logic [pclm_pkg::STATUS_W-1:0]     rsp_tuser   // [1:0] status
);
   import pclm_pkg::*;

   localparam int unsigned IW = $clog2(NODES);
   localparam int unsigned CW = $clog2(NODES + 1);

   pclm_op_type    op;
   pclm_flags_type flags;

   pclm_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .op    (op)
   );

   logic [TYPE_W-1:0]   type_ff, type_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [IW-1:0]       head_ff, head_in;
   logic [IW-1:0]       tail_ff, tail_in;
   logic [IW-1:0]       cur_ff, cur_in;
   logic [IW-1:0]       prev_ff, prev_in;
   logic [IW-1:0]       scan_ff, scan_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [CW-1:0]       walk_ff, walk_in;
   logic [NODES-1:0]    used_ff, used_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IW-1:0]       res_slot_ff, res_slot_in;

   logic [KEY_W-1:0]    key_mem [NODES];
   logic [IW-1:0]       next_mem [NODES];
   logic [KEY_W-1:0]    rd_key_ff;
   logic [IW-1:0]       rd_next_ff;
   logic                key_we;
   logic [IW-1:0]       key_waddr;
   logic                next_we;
   logic [IW-1:0]       next_waddr;
   logic [IW-1:0]       next_wdata;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                rsp_load;
   logic [IW+SLOT_W-1:0]    slot_ext;
   logic [CW+COUNT_W-1:0]   count_ext;

   logic accept;
   logic key_match;
   logic walk_more;
   logic out_free;

   assign req_tready = (op == OP_ACCEPT);
   assign accept     = req_tvalid && req_tready;
   assign key_match  = (rd_key_ff == key_ff);
   assign walk_more  = (CW'(walk_ff + 1'b1) != count_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      flags.accept     = accept;
      flags.is_insert  = (type_ff == REQ_INSERT);
      flags.is_delete  = (type_ff == REQ_DELETE);
      flags.is_clear   = (type_ff == REQ_CLEAR);
      flags.count_full = (count_ff == CW'(NODES));
      flags.count_zero = (count_ff == '0);
      flags.slot_used  = used_ff[scan_ff];
      flags.miss_more  = !key_match && walk_more;
      flags.key_match  = key_match;
      flags.out_free   = out_free;
   end

   always_comb begin
      type_in       = type_ff;
      key_in        = key_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_in        = cur_ff;
      prev_in       = prev_ff;
      scan_in       = scan_ff;
      count_in      = count_ff;
      walk_in       = walk_ff;
      used_in       = used_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      key_we        = 1'b0;
      key_waddr     = cur_ff;
      next_we       = 1'b0;
      next_waddr    = cur_ff;
      next_wdata    = cur_ff;
      rsp_load      = 1'b0;
      unique case (op)
         OP_NOP: begin
         end
         OP_ACCEPT: begin
            if (accept) begin
               type_in = req_tuser;
               key_in  = req_tdata;
            end
         end
         OP_SET_DONE: begin
            res_status_in = ST_DONE;
            res_slot_in   = '0;
         end
         OP_SCAN_INIT: begin
            scan_in = '0;
         end
         OP_SCAN_STEP: begin
            // a pool that is not full always holds a free slot, so the scan stops in range
            cur_in  = scan_ff;
            scan_in = IW'(scan_ff + 1'b1);
         end
         OP_INS_CLAIM: begin
            key_we       = 1'b1;
            if (count_ff == '0) begin
               head_in = cur_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = tail_ff;
               next_wdata = cur_ff;
            end
         end
         OP_INS_LINK: begin
            // head already points at the new slot when the list was empty
            next_we       = 1'b1;
            next_waddr    = cur_ff;
            next_wdata    = head_ff;
            tail_in       = cur_ff;
            used_in[cur_ff] = 1'b1;
            count_in      = CW'(count_ff + 1'b1);
            res_status_in = ST_DONE;
            res_slot_in   = cur_ff;
         end
         OP_SET_FULL: begin
            res_status_in = ST_FULL;
            res_slot_in   = '0;
         end
         OP_WALK_INIT: begin
            cur_in  = head_ff;
            prev_in = tail_ff;
            walk_in = '0;
         end
         OP_WALK_ADV: begin
            // hold on a match or on the last node so the test step sees the same data
            if (!key_match && walk_more) begin
               prev_in = cur_ff;
               cur_in  = rd_next_ff;
               walk_in = CW'(walk_ff + 1'b1);
            end
         end
         OP_SET_MISSING: begin
            res_status_in = ST_MISSING;
            res_slot_in   = '0;
         end
         OP_UNLINK: begin
            if (count_ff == CW'(1)) begin
               head_in = '0;
               tail_in = '0;
            end else if (cur_ff == head_ff) begin
               next_we    = 1'b1;
               next_waddr = tail_ff;
               next_wdata = rd_next_ff;
               head_in    = rd_next_ff;
            end else begin
               next_we    = 1'b1;
               next_waddr = prev_ff;
               next_wdata = rd_next_ff;
               if (cur_ff == tail_ff) begin
                  tail_in = prev_ff;
               end
            end
            used_in[cur_ff] = 1'b0;
            count_in        = CW'(count_ff - 1'b1);
            res_status_in   = ST_DONE;
            res_slot_in     = cur_ff;
         end
         OP_CLEAR: begin
            used_in       = '0;
            head_in       = '0;
            tail_in       = '0;
            count_in      = '0;
            res_status_in = ST_DONE;
            res_slot_in   = '0;
         end
         OP_EMIT: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         used_ff  <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      key_ff        <= key_in;
      cur_ff        <= cur_in;
      prev_ff       <= prev_in;
      scan_ff       <= scan_in;
      walk_ff       <= walk_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
   end

   // read at the next node address so data is ready in the same cycle as the moved pointer
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[key_waddr] <= key_ff;
      end
      rd_key_ff <= key_mem[cur_in];
   end

   always_ff @(posedge clock) begin
      if (next_we) begin
         next_mem[next_waddr] <= next_wdata;
      end
      rd_next_ff <= next_mem[cur_in];
   end

   assign slot_ext  = {{SLOT_W{1'b0}}, res_slot_ff};
   assign count_ext = {{COUNT_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_slot_ff   <= slot_ext[SLOT_W-1:0];
         rsp_count_ff  <= count_ext[COUNT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_W - COUNT_W){1'b0}}, rsp_count_ff, rsp_slot_ff};

   a_count_matches_used: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == int'(count_ff))
      else $error("node count differs from number of used slots");

   a_ends_used: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) |-> (used_ff[head_ff] && used_ff[tail_ff]))
      else $error("head or tail points at a free slot");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (op != OP_INS_LINK && op != OP_UNLINK && op != OP_CLEAR) |=> $stable(count_ff))
      else $error("node count changed outside an insert, delete or clear step");

endmodule

// File: design/pclm_seq.sv
// ----------------------------------------------------------------------------
// pclm_seq: microcode sequencer of the list manager
// Step counter over a read-only program; each control word names one
// datapath operation and a conditional jump taken on a datapath flag.
// ----------------------------------------------------------------------------
module pclm_seq (
   input  logic                  clock,
   input  logic                  reset,
   input  pclm_pkg::pclm_flags_type flags,
   output pclm_pkg::pclm_op_type    op
);
   import pclm_pkg::*;

   localparam logic [PC_W-1:0] STEP_IDLE     = PC_W'(0);
   localparam logic [PC_W-1:0] STEP_DISP_INS = PC_W'(1);
   localparam logic [PC_W-1:0] STEP_DISP_DEL = PC_W'(2);
   localparam logic [PC_W-1:0] STEP_DISP_CLR = PC_W'(3);
   localparam logic [PC_W-1:0] STEP_OTHER    = PC_W'(4);
   localparam logic [PC_W-1:0] STEP_INS0     = PC_W'(5);
   localparam logic [PC_W-1:0] STEP_INS_SCAN = PC_W'(6);
   localparam logic [PC_W-1:0] STEP_INS_CLM  = PC_W'(7);
   localparam logic [PC_W-1:0] STEP_INS_LINK = PC_W'(8);
   localparam logic [PC_W-1:0] STEP_FULL     = PC_W'(9);
   localparam logic [PC_W-1:0] STEP_DEL0     = PC_W'(10);
   localparam logic [PC_W-1:0] STEP_DEL_WALK = PC_W'(11);
   localparam logic [PC_W-1:0] STEP_DEL_TEST = PC_W'(12);
   localparam logic [PC_W-1:0] STEP_MISSING  = PC_W'(13);
   localparam logic [PC_W-1:0] STEP_UNLINK   = PC_W'(14);
   localparam logic [PC_W-1:0] STEP_CLEAR    = PC_W'(15);
   localparam logic [PC_W-1:0] STEP_EMIT     = PC_W'(16);
   localparam logic [PC_W-1:0] STEP_EMIT_W   = PC_W'(17);

   function automatic pclm_ucode_type rom(input logic [PC_W-1:0] addr);
      pclm_ucode_type w;
      unique case (addr)
         STEP_IDLE:     w = '{op: OP_ACCEPT,      cond: C_NO_ACCEPT,  target: STEP_IDLE};
         STEP_DISP_INS: w = '{op: OP_NOP,         cond: C_IS_INSERT,  target: STEP_INS0};
         STEP_DISP_DEL: w = '{op: OP_NOP,         cond: C_IS_DELETE,  target: STEP_DEL0};
         STEP_DISP_CLR: w = '{op: OP_NOP,         cond: C_IS_CLEAR,   target: STEP_CLEAR};
         STEP_OTHER:    w = '{op: OP_SET_DONE,    cond: C_ALWAYS,     target: STEP_EMIT};
         STEP_INS0:     w = '{op: OP_SCAN_INIT,   cond: C_COUNT_FULL, target: STEP_FULL};
         STEP_INS_SCAN: w = '{op: OP_SCAN_STEP,   cond: C_SLOT_USED,  target: STEP_INS_SCAN};
         STEP_INS_CLM:  w = '{op: OP_INS_CLAIM,   cond: C_NEVER,      target: STEP_IDLE};
         STEP_INS_LINK: w = '{op: OP_INS_LINK,    cond: C_ALWAYS,     target: STEP_EMIT};
         STEP_FULL:     w = '{op: OP_SET_FULL,    cond: C_ALWAYS,     target: STEP_EMIT};
         STEP_DEL0:     w = '{op: OP_WALK_INIT,   cond: C_COUNT_ZERO, target: STEP_MISSING};
         STEP_DEL_WALK: w = '{op: OP_WALK_ADV,    cond: C_MISS_MORE,  target: STEP_DEL_WALK};
         STEP_DEL_TEST: w = '{op: OP_NOP,         cond: C_KEY_MATCH,  target: STEP_UNLINK};
         STEP_MISSING:  w = '{op: OP_SET_MISSING, cond: C_ALWAYS,     target: STEP_EMIT};
         STEP_UNLINK:   w = '{op: OP_UNLINK,      cond: C_ALWAYS,     target: STEP_EMIT};
         STEP_CLEAR:    w = '{op: OP_CLEAR,       cond: C_ALWAYS,     target: STEP_EMIT};
         STEP_EMIT:     w = '{op: OP_EMIT,        cond: C_OUT_FREE,   target: STEP_IDLE};
         STEP_EMIT_W:   w = '{op: OP_NOP,         cond: C_ALWAYS,     target: STEP_EMIT};
         default:       w = '{op: OP_NOP,         cond: C_ALWAYS,     target: STEP_IDLE};
      endcase
      return w;
   endfunction

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   pclm_ucode_type  word;
   logic            take;

   always_comb begin
      word = rom(pc_ff);
      unique case (word.cond)
         C_NEVER:      take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_NO_ACCEPT:  take = !flags.accept;
         C_IS_INSERT:  take = flags.is_insert;
         C_IS_DELETE:  take = flags.is_delete;
         C_IS_CLEAR:   take = flags.is_clear;
         C_COUNT_FULL: take = flags.count_full;
         C_COUNT_ZERO: take = flags.count_zero;
         C_SLOT_USED:  take = flags.slot_used;
         C_MISS_MORE:  take = flags.miss_more;
         C_KEY_MATCH:  take = flags.key_match;
         C_OUT_FREE:   take = flags.out_free;
         default:      take = 1'b0;
      endcase
      pc_in = take ? word.target : PC_W'(pc_ff + 1'b1);
      op    = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
